>>> sv/assert_macros.svh
// Assertion macros used by the delta patch decoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define BDPD_ASSERT(lbl, clk_s, rstn_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
    else $error("bdpd assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BDPD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("bdpd assertion failed");

`endif

>>> sv/bdpd_pkg.sv
// Types, constants and helpers for the delta patch decoder.
`timescale 1ns / 1ps

package bdpd_pkg;

  localparam logic [7:0] ESC_BYTE = 8'hA7;
  localparam logic [7:0] OP_MOD   = 8'hA6;
  localparam logic [7:0] OP_INS   = 8'hA5;
  localparam logic [7:0] OP_DEL   = 8'hA4;
  localparam logic [7:0] OP_EQL   = 8'hA3;
  localparam logic [7:0] OP_BKT   = 8'hA2;

  // Count lead byte codes
  localparam logic [7:0] LEAD_ADD  = 8'd252;
  localparam logic [7:0] LEAD_TWO  = 8'd253;
  localparam logic [7:0] LEAD_FOUR = 8'd254;

  localparam logic [63:0] ADD_BASE = 64'd253;

  localparam logic [3:0] LEFT_NONE  = 4'd0;
  localparam logic [3:0] LEFT_ONE   = 4'd1;
  localparam logic [3:0] LEFT_TWO   = 4'd2;
  localparam logic [3:0] LEFT_FOUR  = 4'd4;
  localparam logic [3:0] LEFT_EIGHT = 4'd8;

  localparam logic signed [63:0] SKIP_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SKIP_MIN = 64'sh8000_0000_0000_0000;

  localparam int CMD_FIFO_DEPTH = 2;
  localparam int CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);
  localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NONE, MODE_MOD, MODE_INS, MODE_DEL, MODE_EQL, MODE_BKT
  } mode_t;

  typedef enum logic [1:0] {
    ACT_LIT, ACT_SEEK, ACT_COPY, ACT_ERR
  } action_t;

  typedef enum logic [1:0] {
    FORM_LEAD, FORM_BYTES, FORM_ADD
  } len_form_t;

  typedef enum logic [2:0] {
    CMD_LIT1, CMD_LIT2, CMD_DEL, CMD_EQL, CMD_BKT, CMD_ERR
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [7:0]         data;
    logic               modify;
    logic signed [63:0] count;
  } cmd_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      return a[63] ? SKIP_MIN : SKIP_MAX;
    end
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] d;
    d = a - b;
    if ((a[63] != b[63]) && (d[63] != a[63])) begin
      return a[63] ? SKIP_MIN : SKIP_MAX;
    end
    return d;
  endfunction

endpackage

>>> sv/binary_delta_patch_decoder_unit.sv
// Top level of the delta patch decoder: front end, command queue, back end.
// A taken beat goes into the command queue, then the back end loads the result register.
// Throughput: one patch beat per cycle while the two-entry queue is not full; a beat with
// two results holds the back end for both; the single result register takes one at a time.
// Reset (rst_n, synchronous, active low): mode none, no escape, no count, skip zero,
// error halt cleared, queue empty, no result valid, wide lengths enabled.
`timescale 1ns / 1ps

module binary_delta_patch_decoder_unit import bdpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_patch_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_action,
  output logic [7:0]         out_data_byte,
  output logic signed [63:0] out_amount,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_wide_lengths_enable
);

  // Commands from the front end: one per patch beat that yields results.
  logic push;
  cmd_t push_cmd;
  logic fifo_full;

  // Queue head as seen by the back end.
  logic head_valid;
  cmd_t head;
  logic pop;

  // Front: escape decoding, mode, count assembly and the sticky error halt.
  bdpd_front u_front (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_patch_byte           (in_patch_byte),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_wide_lengths_enable (cfg_wide_lengths_enable),
    .push                    (push),
    .push_cmd                (push_cmd),
    .fifo_full               (fifo_full)
  );

  // Queue lets the front keep taking beats while results wait downstream.
  bdpd_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: pending skip, saturating seek arithmetic and the result register.
  bdpd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_action    (out_action),
    .out_data_byte (out_data_byte),
    .out_amount    (out_amount),
    .out_last      (out_last)
  );

endmodule

>>> sv/bdpd_front.sv
// Front end: takes patch bytes, tracks escapes and counts, issues commands.
`timescale 1ns / 1ps

module bdpd_front import bdpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_patch_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_wide_lengths_enable,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       fifo_full
);

  mode_t       mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [3:0]  left_r, left_nxt;
  len_form_t   form_r, form_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        halted_r, halted_nxt;
  logic        wide_r;

  logic        accept;
  logic        emit_ok;
  logic        is_mod;
  cmd_op_t     fin_op;
  logic [63:0] shifted;

  assign in_ready  = !fifo_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign emit_ok   = (mode_r == MODE_MOD) || (mode_r == MODE_INS);
  assign is_mod    = (mode_r == MODE_MOD);
  assign shifted   = {acc_r[55:0], in_patch_byte};

  always_comb begin
    case (mode_r)
      MODE_DEL: fin_op = CMD_DEL;
      MODE_BKT: fin_op = CMD_BKT;
      default:  fin_op = CMD_EQL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b1;
    end else if (cfg_valid) begin
      wide_r <= cfg_wide_lengths_enable;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_NONE;
      esc_r    <= 1'b0;
      left_r   <= LEFT_NONE;
      form_r   <= FORM_LEAD;
      acc_r    <= '0;
      halted_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      esc_r    <= esc_nxt;
      left_r   <= left_nxt;
      form_r   <= form_nxt;
      acc_r    <= acc_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    esc_nxt         = esc_r;
    left_nxt        = left_r;
    form_nxt        = form_r;
    acc_nxt         = acc_r;
    halted_nxt      = halted_r;
    push            = 1'b0;
    push_cmd.op     = CMD_LIT1;
    push_cmd.data   = in_patch_byte;
    push_cmd.modify = is_mod;
    push_cmd.count  = '0;

    if (accept && !halted_r) begin
      if (left_r != LEFT_NONE) begin
        // raw count bytes, no escape handling here
        push_cmd.op = fin_op;
        case (form_r)
          FORM_LEAD: begin
            if (in_patch_byte < LEAD_ADD) begin
              push           = 1'b1;
              push_cmd.count = {56'd0, in_patch_byte} + 64'd1;
              left_nxt       = LEFT_NONE;
            end else if (in_patch_byte == LEAD_ADD) begin
              acc_nxt  = ADD_BASE;
              form_nxt = FORM_ADD;
              left_nxt = LEFT_ONE;
            end else if (in_patch_byte == LEAD_TWO) begin
              acc_nxt  = '0;
              form_nxt = FORM_BYTES;
              left_nxt = LEFT_TWO;
            end else if (in_patch_byte == LEAD_FOUR) begin
              acc_nxt  = '0;
              form_nxt = FORM_BYTES;
              left_nxt = LEFT_FOUR;
            end else if (wide_r) begin
              acc_nxt  = '0;
              form_nxt = FORM_BYTES;
              left_nxt = LEFT_EIGHT;
            end else begin
              push        = 1'b1;
              push_cmd.op = CMD_ERR;
              halted_nxt  = 1'b1;
              left_nxt    = LEFT_NONE;
              form_nxt    = FORM_LEAD;
            end
          end
          FORM_ADD: begin
            push           = 1'b1;
            push_cmd.count = acc_r + {56'd0, in_patch_byte};
            left_nxt       = LEFT_NONE;
            form_nxt       = FORM_LEAD;
          end
          FORM_BYTES: begin
            acc_nxt  = shifted;
            left_nxt = left_r - LEFT_ONE;
            if (left_r == LEFT_ONE) begin
              push           = 1'b1;
              push_cmd.count = shifted;
              form_nxt       = FORM_LEAD;
            end
          end
          default: begin
            left_nxt = LEFT_NONE;
            form_nxt = FORM_LEAD;
          end
        endcase
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        case (in_patch_byte)
          OP_MOD: mode_nxt = MODE_MOD;
          OP_INS: mode_nxt = MODE_INS;
          OP_DEL, OP_EQL, OP_BKT: begin
            if (in_patch_byte == OP_DEL) begin
              mode_nxt = MODE_DEL;
            end else if (in_patch_byte == OP_EQL) begin
              mode_nxt = MODE_EQL;
            end else begin
              mode_nxt = MODE_BKT;
            end
            left_nxt = LEFT_ONE;
            form_nxt = FORM_LEAD;
            acc_nxt  = '0;
          end
          ESC_BYTE: push = emit_ok;
          default: begin
            push        = emit_ok;
            push_cmd.op = CMD_LIT2;
          end
        endcase
      end else if (in_patch_byte == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        push = emit_ok;
      end
    end
  end

endmodule

>>> sv/bdpd_cmd_fifo.sv
// Short command queue between front and back ends.
`timescale 1ns / 1ps

module bdpd_cmd_fifo import bdpd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t                 mem_r [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CMD_CNT_W-1:0] count_r;

  assign full       = (count_r == CMD_CNT_W'(CMD_FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> sv/bdpd_back.sv
// Back end: runs commands against the pending skip, drives the result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdpd_back import bdpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_valid,
  input  cmd_t               head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_action,
  output logic [7:0]         out_data_byte,
  output logic signed [63:0] out_amount,
  output logic               out_last
);

  logic signed [63:0] ps_r, ps_nxt;
  logic               phase_r, phase_nxt;
  logic               out_valid_r, out_valid_nxt;
  action_t            act_r;
  logic [7:0]         data_r;
  logic signed [63:0] amt_r;
  logic               last_r;

  logic               load_en;
  logic               emit;
  action_t            r_act;
  logic [7:0]         r_data;
  logic signed [63:0] r_amt;
  logic               r_last;
  logic signed [63:0] ps_inc;
  logic               copy_need;
  logic               fin_pop;

  assign load_en   = !out_valid_r || out_ready;
  assign ps_inc    = (ps_r == SKIP_MAX) ? ps_r : ps_r + 64'sd1;
  assign copy_need = !head.count[63] && (head.count != '0);
  assign fin_pop   = pop && (head.op inside {CMD_DEL, CMD_BKT, CMD_EQL});

  always_comb begin
    ps_nxt    = ps_r;
    phase_nxt = phase_r;
    pop       = 1'b0;
    emit      = 1'b0;
    r_act     = ACT_LIT;
    r_data    = '0;
    r_amt     = '0;
    r_last    = 1'b1;
    if (head_valid && load_en) begin
      case (head.op)
        CMD_LIT1: begin
          emit   = 1'b1;
          r_data = head.data;
          pop    = 1'b1;
          if (head.modify) ps_nxt = ps_inc;
        end
        CMD_LIT2: begin
          emit = 1'b1;
          if (head.modify) ps_nxt = ps_inc;
          if (!phase_r) begin
            r_data    = ESC_BYTE;
            r_last    = 1'b0;
            phase_nxt = 1'b1;
          end else begin
            r_data    = head.data;
            phase_nxt = 1'b0;
            pop       = 1'b1;
          end
        end
        CMD_DEL: begin
          emit   = 1'b1;
          r_act  = ACT_SEEK;
          r_amt  = sat_add(head.count, ps_r);
          ps_nxt = '0;
          pop    = 1'b1;
        end
        CMD_BKT: begin
          emit   = 1'b1;
          r_act  = ACT_SEEK;
          r_amt  = sat_sub(ps_r, head.count);
          ps_nxt = '0;
          pop    = 1'b1;
        end
        CMD_EQL: begin
          // seek first if a skip is pending; the copy, if any, follows as the next result
          if (ps_r != '0) begin
            emit   = 1'b1;
            r_act  = ACT_SEEK;
            r_amt  = ps_r;
            r_last = !copy_need;
            ps_nxt = '0;
            pop    = !copy_need;
          end else begin
            emit  = copy_need;
            r_act = ACT_COPY;
            r_amt = head.count;
            pop   = 1'b1;
          end
        end
        CMD_ERR: begin
          emit  = 1'b1;
          r_act = ACT_ERR;
          pop   = 1'b1;
        end
        default: pop = 1'b1;
      endcase
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r        <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ps_r        <= ps_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      act_r  <= r_act;
      data_r <= r_data;
      amt_r  <= r_amt;
      last_r <= r_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = act_r;
  assign out_data_byte = data_r;
  assign out_amount    = amt_r;
  assign out_last      = last_r;

  `BDPD_ASSERT(a_phase_on_lit2, clk, rst_n, !phase_r || (head_valid && head.op == CMD_LIT2))
  `BDPD_ASSERT(a_skip_nonneg, clk, rst_n, !ps_r[63])
  `BDPD_ASSERT_NEXT(a_finish_clears_skip, clk, rst_n, fin_pop, ps_r == '0)

endmodule
